// ===== hw/rtl/bdl_pkg.sv =====
package bdl_pkg;

  localparam int unsigned CAPACITY    = 256;
  localparam int unsigned ENTRY_WIDTH = 32;

  localparam int unsigned PTR_W = $clog2(CAPACITY);
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned SUM_W = PTR_W + 1;

  typedef enum logic [2:0] {
    OP_INS_HEAD = 3'd0,
    OP_INS_TAIL = 3'd1,
    OP_REM_HEAD = 3'd2,
    OP_REM_TAIL = 3'd3,
    OP_READ     = 3'd4
  } op_e;

  typedef struct packed {
    logic                   we;
    logic                   re;
    logic [PTR_W-1:0]       addr;
    logic [ENTRY_WIDTH-1:0] wdata;
  } mem_req_t;

  typedef struct packed {
    logic             accepted;
    logic             read_valid;
    logic [CNT_W-1:0] size;
  } res_t;

  // Ring slot of a logical offset from the head; offset never exceeds CAPACITY.
  function automatic logic [PTR_W-1:0] ring_pos(logic [PTR_W-1:0] head,
                                                logic [CNT_W-1:0] offset);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(head) + SUM_W'(offset);
    if (sum >= SUM_W'(CAPACITY)) begin
      sum = sum - SUM_W'(CAPACITY);
    end
    return sum[PTR_W-1:0];
  endfunction

endpackage

// ===== hw/rtl/bounded_double_ended_list.sv =====
// A result word is registered and presented in the cycle after its operation is accepted.
// Throughput: one operation per cycle when not stalled; each operation makes at most one access
// to the single-port entry memory, and the head/count update completes in that cycle.
// Input stalls only while a presented result is itself stalled.
// Reset clears the head pointer, entry count and output valid; entry memory
// contents are left as they are and are never cleared.
module bounded_double_ended_list (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  operation_i,
  input  logic [31:0] entry_value_i,
  input  logic [7:0]  entry_index_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] read_value_o,
  output logic        read_valid_o,
  output logic        accepted_o,
  output logic [8:0]  list_size_o
);

  logic                                out_valid_q;
  bdl_pkg::res_t                       res_q;
  bdl_pkg::res_t                       res;
  bdl_pkg::mem_req_t                   mem_req;
  logic [bdl_pkg::ENTRY_WIDTH-1:0]     rdata;
  logic                                fire;

  assign in_stall_o = out_valid_q & out_stall_i;
  assign fire       = in_valid_i & ~in_stall_o;

  bdl_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fire_i       (fire),
    .operation_i  (operation_i),
    .entry_value_i(entry_value_i),
    .entry_index_i(entry_index_i),
    .mem_req_o    (mem_req),
    .res_o        (res)
  );

  bdl_ram #(
    .DEPTH(bdl_pkg::CAPACITY),
    .WIDTH(bdl_pkg::ENTRY_WIDTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (mem_req.we),
    .re_i   (mem_req.re),
    .addr_i (mem_req.addr),
    .wdata_i(mem_req.wdata),
    .rdata_o(rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      out_valid_q <= fire;
    end
  end

  // Advance the result word on every accepted operation; hold otherwise.
  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_q <= res;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign read_valid_o = res_q.read_valid;
  assign read_value_o = res_q.read_valid ? 32'(rdata) : 32'd0;
  assign accepted_o   = res_q.accepted;
  assign list_size_o  = 9'(res_q.size);

endmodule

// ===== hw/rtl/bdl_ram.sv =====
module bdl_ram #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned WIDTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
  end

  // Hold read data until the next read.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/bdl_ctrl.sv =====
module bdl_ctrl (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     fire_i,
  input  logic [2:0]               operation_i,
  input  logic [31:0]              entry_value_i,
  input  logic [7:0]               entry_index_i,
  output bdl_pkg::mem_req_t        mem_req_o,
  output bdl_pkg::res_t            res_o
);

  logic [bdl_pkg::PTR_W-1:0] head_q, head_d, head_dec;
  logic [bdl_pkg::CNT_W-1:0] count_q, count_d;
  logic                      full, empty, idx_ok;
  bdl_pkg::op_e              op;
  bdl_pkg::mem_req_t         req;
  bdl_pkg::res_t             res;

  assign op       = bdl_pkg::op_e'(operation_i);
  assign full     = (count_q == bdl_pkg::CNT_W'(bdl_pkg::CAPACITY));
  assign empty    = (count_q == '0);
  assign idx_ok   = (int'(entry_index_i) < int'(count_q));
  assign head_dec = (head_q == '0) ? bdl_pkg::PTR_W'(bdl_pkg::CAPACITY - 1)
                                   : head_q - 1'b1;

  always_comb begin
    head_d         = head_q;
    count_d        = count_q;
    req.we         = 1'b0;
    req.re         = 1'b0;
    req.addr       = head_q;
    req.wdata      = bdl_pkg::ENTRY_WIDTH'(entry_value_i);
    res.accepted   = 1'b0;
    res.read_valid = 1'b0;
    unique case (op)
      bdl_pkg::OP_INS_HEAD: begin
        if (!full) begin
          head_d       = head_dec;
          count_d      = count_q + 1'b1;
          req.we       = 1'b1;
          req.addr     = head_dec;
          res.accepted = 1'b1;
        end
      end
      bdl_pkg::OP_INS_TAIL: begin
        if (!full) begin
          count_d      = count_q + 1'b1;
          req.we       = 1'b1;
          req.addr     = bdl_pkg::ring_pos(head_q, count_q);
          res.accepted = 1'b1;
        end
      end
      bdl_pkg::OP_REM_HEAD: begin
        if (!empty) begin
          head_d       = bdl_pkg::ring_pos(head_q, bdl_pkg::CNT_W'(1));
          count_d      = count_q - 1'b1;
          res.accepted = 1'b1;
        end
      end
      bdl_pkg::OP_REM_TAIL: begin
        if (!empty) begin
          count_d      = count_q - 1'b1;
          res.accepted = 1'b1;
        end
      end
      bdl_pkg::OP_READ: begin
        if (idx_ok) begin
          req.re         = 1'b1;
          req.addr       = bdl_pkg::ring_pos(head_q, bdl_pkg::CNT_W'(entry_index_i));
          res.read_valid = 1'b1;
        end
      end
      default: begin
      end
    endcase
    res.size = count_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      count_q <= '0;
    end else if (fire_i) begin
      head_q  <= head_d;
      count_q <= count_d;
    end
  end

  always_comb begin
    mem_req_o    = req;
    mem_req_o.we = req.we & fire_i;
    mem_req_o.re = req.re & fire_i;
  end

  assign res_o = res;

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(count_q) <= int'(bdl_pkg::CAPACITY))
    else $error("entry count above capacity");

  a_no_write_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full |-> !mem_req_o.we)
    else $error("write issued into a full list");

  a_size_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && res.accepted && mem_req_o.we) |=> (count_q == $past(count_q) + 1'b1))
    else $error("accepted insert did not grow the list by one");

  a_read_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_req_o.re |-> (!empty && !mem_req_o.we))
    else $error("read issued on an empty list or together with a write");
`endif

endmodule
